FILE: rtl/hse_pkg.sv
package hse_pkg;

    // Width of one stored value, fixed by the item format.
    localparam int VALUE_W = 32;

    // A value as it travels on the ports and through the sort datapath.
    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

FILE: rtl/heap_sort_engine.sv
// Heap sort engine. Signed 32-bit values arrive one item per cycle on the
// input channel and are written into a store of DEPTH entries (one write
// port, one read port); values that find the store full are dropped and the
// set is marked as overflowed. The item flagged last also carries a value,
// and once it is taken the input stalls while the stored set is heap sorted
// in place: a max-heap is built bottom-up, then the top is repeatedly moved
// to the end of the shrinking heap and the displaced entry is sifted back
// down. One shared signed comparator and the single read port of the store
// set the pace: each level of a sift needs at most a bounds check, then a read
// of each child, with the decision taken as the right child arrives; each
// sift of the build phase first fetches its node, and each extraction first
// fetches the top and the last leaf. The sorted set then leaves in ascending
// order, one result item at a time: each is read from the store and then
// loaded into the output register once that register is free, with final_res
// on the last one and overflowed repeated on all of them. The input is ready
// again as soon as the last result has been loaded into the output register,
// so a new set can start filling while that result still waits to be taken.
// The store needs no clearing after reset because only entries written for
// the current set are ever read.
module heap_sort_engine #(
    parameter int DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,

    input  logic            item_valid,
    output logic            item_ready,
    input  hse_pkg::value_t value,
    input  logic            last,

    output logic            res_valid,
    input  logic            res_ready,
    output hse_pkg::value_t sorted_value,
    output logic            final_res,
    output logic            overflowed
);

    import hse_pkg::*;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    // Child indices of the deepest node can exceed the address range.
    localparam int CHILD_W = ADDR_W + 2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BUILD_NEXT,
        ST_SIFT_CUR,
        ST_SIFT_CHK,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_EXT_NEXT,
        ST_EXT_TOP,
        ST_EXT_END,
        ST_OUT_RD,
        ST_OUT_CAP
    } state_t;

    // Control state.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_count_reg, fill_count_next;
    logic               dropped_reg, dropped_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [ADDR_W-1:0]  node_reg, node_next;
    logic [CNT_W-1:0]   hlen_reg, hlen_next;
    logic               build_reg, build_next;
    logic               best_is_l_reg, best_is_l_next;
    logic               res_valid_reg, res_valid_next;

    // Datapath and output payload.
    value_t             cur_reg, cur_next;
    value_t             best_reg, best_next;
    value_t             sorted_value_reg, sorted_value_next;
    logic               final_res_reg, final_res_next;
    logic               overflowed_reg, overflowed_next;

    // Store port.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_wr_addr;
    value_t             ram_wr_data;
    logic [ADDR_W-1:0]  ram_rd_addr;
    value_t             rd_data;

    // Shared comparator and index arithmetic.
    value_t             cmp_b;
    logic               cmp_gt;
    logic [CHILD_W-1:0] lc;
    logic [CHILD_W-1:0] rc;
    logic [CHILD_W-1:0] hlen_ext;
    logic [CNT_W-1:0]   k_dec;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   fill_inc;
    state_t             ret_state;

    hse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    assign lc        = CHILD_W'({node_reg, 1'b1});
    assign rc        = lc + CHILD_W'(1);
    assign hlen_ext  = CHILD_W'(hlen_reg);
    assign k_dec     = k_reg - CNT_W'(1);
    assign k_inc     = k_reg + CNT_W'(1);
    assign fill_inc  = fill_count_reg + CNT_W'(1);
    assign ret_state = build_reg ? ST_BUILD_NEXT : ST_EXT_NEXT;

    // The single comparator always sees the value just read from the store.
    // Against the sifted entry when the left child arrives, and against the
    // larger of the two when the right child arrives.
    assign cmp_b  = (state_reg == ST_SIFT_R) ? best_reg : cur_reg;
    assign cmp_gt = rd_data > cmp_b;

    assign item_ready   = (state_reg == ST_LOAD);
    assign res_valid    = res_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign final_res    = final_res_reg;
    assign overflowed   = overflowed_reg;

    always_comb
    begin
        state_next        = state_reg;
        fill_count_next   = fill_count_reg;
        dropped_next      = dropped_reg;
        k_next            = k_reg;
        node_next         = node_reg;
        hlen_next         = hlen_reg;
        build_next        = build_reg;
        best_is_l_next    = best_is_l_reg;
        res_valid_next    = res_valid_reg && !res_ready;
        cur_next          = cur_reg;
        best_next         = best_reg;
        sorted_value_next = sorted_value_reg;
        final_res_next    = final_res_reg;
        overflowed_next   = overflowed_reg;
        ram_we            = 1'b0;
        ram_wr_addr       = node_reg;
        ram_wr_data       = cur_reg;
        ram_rd_addr       = k_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_valid)
                begin
                    if (fill_count_reg < CNT_W'(DEPTH))
                    begin
                        ram_we          = 1'b1;
                        ram_wr_addr     = fill_count_reg[ADDR_W-1:0];
                        ram_wr_data     = value;
                        fill_count_next = fill_inc;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        k_next     = fill_count_next >> 1;
                        build_next = 1'b1;
                        state_next = ST_BUILD_NEXT;
                    end
                end
            end

            ST_BUILD_NEXT:
            begin
                if (k_reg == '0)
                begin
                    build_next = 1'b0;
                    k_next     = fill_count_reg;
                    state_next = ST_EXT_NEXT;
                end
                else
                begin
                    ram_rd_addr = k_dec[ADDR_W-1:0];
                    node_next   = k_dec[ADDR_W-1:0];
                    hlen_next   = fill_count_reg;
                    k_next      = k_dec;
                    state_next  = ST_SIFT_CUR;
                end
            end

            ST_SIFT_CUR:
            begin
                cur_next   = rd_data;
                state_next = ST_SIFT_CHK;
            end

            ST_SIFT_CHK:
            begin
                if (lc < hlen_ext)
                begin
                    ram_rd_addr = lc[ADDR_W-1:0];
                    state_next  = ST_SIFT_L;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = ret_state;
                end
            end

            ST_SIFT_L:
            begin
                best_next      = cmp_gt ? rd_data : cur_reg;
                best_is_l_next = cmp_gt;
                if (rc < hlen_ext)
                begin
                    ram_rd_addr = rc[ADDR_W-1:0];
                    state_next  = ST_SIFT_R;
                end
                else if (cmp_gt)
                begin
                    ram_we      = 1'b1;
                    ram_wr_data = rd_data;
                    node_next   = lc[ADDR_W-1:0];
                    state_next  = ST_SIFT_CHK;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = ret_state;
                end
            end

            ST_SIFT_R:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    ram_wr_data = rd_data;
                    node_next   = rc[ADDR_W-1:0];
                    state_next  = ST_SIFT_CHK;
                end
                else if (best_is_l_reg)
                begin
                    ram_wr_data = best_reg;
                    node_next   = lc[ADDR_W-1:0];
                    state_next  = ST_SIFT_CHK;
                end
                else
                begin
                    state_next = ret_state;
                end
            end

            ST_EXT_NEXT:
            begin
                if (k_reg <= CNT_W'(1))
                begin
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    ram_rd_addr = '0;
                    state_next  = ST_EXT_TOP;
                end
            end

            ST_EXT_TOP:
            begin
                best_next   = rd_data;
                ram_rd_addr = k_dec[ADDR_W-1:0];
                state_next  = ST_EXT_END;
            end

            ST_EXT_END:
            begin
                cur_next    = rd_data;
                ram_we      = 1'b1;
                ram_wr_addr = k_dec[ADDR_W-1:0];
                ram_wr_data = best_reg;
                node_next   = '0;
                hlen_next   = k_dec;
                k_next      = k_dec;
                state_next  = ST_SIFT_CHK;
            end

            ST_OUT_RD:
            begin
                state_next = ST_OUT_CAP;
            end

            ST_OUT_CAP:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next    = 1'b1;
                    sorted_value_next = rd_data;
                    final_res_next    = (k_inc == fill_count_reg);
                    overflowed_next   = dropped_reg;
                    if (k_inc == fill_count_reg)
                    begin
                        fill_count_next = '0;
                        dropped_next    = 1'b0;
                        state_next      = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
            k_reg          <= '0;
            node_reg       <= '0;
            hlen_reg       <= '0;
            build_reg      <= 1'b0;
            best_is_l_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
            k_reg          <= k_next;
            node_reg       <= node_next;
            hlen_reg       <= hlen_next;
            build_reg      <= build_next;
            best_is_l_reg  <= best_is_l_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg          <= cur_next;
        best_reg         <= best_next;
        sorted_value_reg <= sorted_value_next;
        final_res_reg    <= final_res_next;
        overflowed_reg   <= overflowed_next;
    end

    // The number of held values never exceeds the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(DEPTH))
    else $error("fill count beyond store depth");

    // The node being sifted always lies inside the active heap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIFT_CHK || state_reg == ST_SIFT_L || state_reg == ST_SIFT_R)
        |-> (CNT_W'(node_reg) < hlen_reg))
    else $error("sift node outside the heap");

    // The active heap never reaches past the values held for the set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIFT_CHK || state_reg == ST_SIFT_L || state_reg == ST_SIFT_R)
        |-> (hlen_reg <= fill_count_reg))
    else $error("heap length beyond the held set");

    // Output results are only loaded while the set is being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg)) |-> ($past(state_reg) == ST_OUT_CAP))
    else $error("result appeared outside the output phase");

endmodule

FILE: rtl/hse_ram.sv
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
